[sv/ormrb_pkg.sv]
// Package for the overwriting message ring buffer unit.
// Holds opcode and status codes and record format constants.
// No dependencies.
package ormrb_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_START = 2'd0,
    OP_PUSH_DATA  = 2'd1,
    OP_PULL       = 2'd2,
    OP_REWIND     = 2'd3
  } opcode_e;

  localparam logic [1:0]  ST_OK        = 2'd0;
  localparam logic [1:0]  ST_EMPTY     = 2'd1;
  localparam logic [1:0]  ST_TOO_LARGE = 2'd2;

  localparam logic [15:0] HDR_BYTES    = 16'd2;
  localparam logic [11:0] MAX_LEN      = 12'd4094;
  localparam logic [12:0] RING_MIN     = 13'd16;
  localparam logic [12:0] RING_RESET   = 13'd4096;

endpackage

[sv/overwriting_message_ring_buffer_unit.sv]
// Top level of the overwriting message ring buffer unit.
// Depends on ormrb_pkg and ormrb_ram.
//
// Channel       Direction  Handshake           Payload
// command       in         start_i / busy_o    opcode_i, msg_length_i, data_byte_i
// result        out        done_o (one cycle)  out_byte_o, out_length_o, last_byte_o, status_o
// configuration in         cfg_we_i            cfg_wdata_i (ring size)
//
// Every command transaction yields exactly one result transaction, flagged by
// done_o for one cycle. A push data byte, a rewind, a rejected push or a pull
// with the cursor invalid completes straight from the idle state. A pull reads
// the header at the cursor and ends there if it is empty; otherwise it reads one
// payload byte, and when that byte ends a record it also reads the newest header.
// A push start reads the newest record's header, then reads the header of each
// dropped record after a drop test, on a wrap writes a padding header and reads
// one more header, and last writes its own header. After reset the store is
// cleared one byte a cycle with busy_o high. The result side cannot stall, so no
// result is ever held.
module overwriting_message_ring_buffer_unit #(
  parameter int CAPACITY = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  ormrb_pkg::opcode_e    opcode_i,
  input  logic [11:0]           msg_length_i,
  input  logic [7:0]            data_byte_i,
  output logic                  done_o,
  output logic [7:0]            out_byte_o,
  output logic [11:0]           out_length_o,
  output logic                  last_byte_o,
  output logic [1:0]            status_o,
  input  logic                  cfg_we_i,
  input  logic [12:0]           cfg_wdata_i
);

  import ormrb_pkg::*;

  // Position width and the width of sums of a position and a header.
  localparam int PW = $clog2(CAPACITY);
  localparam int SW = ((PW > 16) ? PW : 16) + 2;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_HLO   = 11'b00000000100,
    S_HHI   = 11'b00000001000,
    S_HEND  = 11'b00000010000,
    S_DROP  = 11'b00000100000,
    S_WNLO  = 11'b00001000000,
    S_WNHI  = 11'b00010000000,
    S_PHLO  = 11'b00100000000,
    S_PHHI  = 11'b01000000000,
    S_PBYTE = 11'b10000000000
  } state_e;

  // What a finished header read is used for.
  typedef enum logic [2:0] {
    R_NEWEST = 3'd0,
    R_DROP   = 3'd1,
    R_WRAP   = 3'd2,
    R_PULL   = 3'd3,
    R_PULLN  = 3'd4
  } hret_e;

  // Increment an address, wrapping at the end of the store.
  function automatic logic [PW-1:0] inc_addr(input logic [PW-1:0] a);
    logic [PW:0] s;
    s = {1'b0, a} + (PW+1)'(1);
    return (s >= (PW+1)'(CAPACITY)) ? '0 : s[PW-1:0];
  endfunction

  // Address of the first payload byte of the record at p.
  function automatic logic [PW-1:0] add2(input logic [PW-1:0] p);
    logic [PW:0] s;
    s = {1'b0, p} + (PW+1)'(2);
    return (s >= (PW+1)'(CAPACITY)) ? PW'(s - (PW+1)'(CAPACITY)) : s[PW-1:0];
  endfunction

  // Position of the record after the one at pos, or 0 at the ring's end or for a zero size.
  function automatic logic [PW-1:0] next_rec(input logic [PW-1:0] pos,
                                             input logic [15:0] sz,
                                             input logic [SW-1:0] rl);
    logic [SW-1:0] nxt;
    nxt = SW'(pos) + SW'(sz);
    return (sz != 16'd0 && nxt < rl) ? nxt[PW-1:0] : '0;
  endfunction

  state_e        state_q, state_d;
  hret_e         ret_q, ret_d;
  logic [12:0]   ring_size_q;
  logic [PW-1:0] oldest_q, oldest_d;
  logic [PW-1:0] newest_q, newest_d;
  logic [PW-1:0] pull_pos_q, pull_pos_d;
  logic [PW-1:0] pull_addr_q, pull_addr_d;
  logic          pull_valid_q, pull_valid_d;
  logic [PW-1:0] write_ptr_q, write_ptr_d;
  logic [11:0]   push_rem_q, push_rem_d;
  logic [11:0]   pull_off_q, pull_off_d;
  logic [PW-1:0] clr_cnt_q, clr_cnt_d;
  logic [PW-1:0] hpos_q, hpos_d;
  logic [7:0]    hlo_q, hlo_d;
  logic [SW-1:0] npos_q, npos_d;
  logic [SW-1:0] end_q, end_d;
  logic [12:0]   nsz_q, nsz_d;
  logic [11:0]   len_q, len_d;
  logic          phase_q, phase_d;
  logic [15:0]   sz_q, sz_d;
  logic [11:0]   plen_q, plen_d;
  logic          rdflag_q, rdflag_d;
  logic [7:0]    byte_q, byte_d;

  logic          done_q, done_d;
  logic [7:0]    obyte_q, obyte_d;
  logic [11:0]   olen_q, olen_d;
  logic          olast_q, olast_d;
  logic [1:0]    ostat_q, ostat_d;

  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [PW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic [SW-1:0] ring_len;
  logic [15:0]   hdr;
  logic [12:0]   nsz_in;
  logic [15:0]   pad_sz;
  logic [15:0]   plen_raw;
  logic [11:0]   off_new;
  logic [SW-1:0] tail;
  logic [PW-1:0] nxt_pull;
  logic          drop_more;

  ormrb_ram #(
    .DEPTH (CAPACITY),
    .AW    (PW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Ring length in use, raised to RING_MIN and saturated to the store.
  always_comb begin
    if (ring_size_q < RING_MIN) begin
      ring_len = SW'(RING_MIN);
    end else if (SW'(ring_size_q) > SW'(CAPACITY)) begin
      ring_len = SW'(CAPACITY);
    end else begin
      ring_len = SW'(ring_size_q);
    end
  end

  assign hdr       = {mem_rdata, hlo_q};
  assign nsz_in    = {1'b0, msg_length_i} + 13'd2;
  assign pad_sz    = 16'(ring_len) - 16'(newest_q);
  assign plen_raw  = hdr - HDR_BYTES;
  assign off_new   = pull_off_q + {11'd0, rdflag_q};
  assign tail      = SW'(newest_q) + SW'(hdr);
  assign nxt_pull  = next_rec(pull_pos_q, sz_q, ring_len);
  assign drop_more = (oldest_q > newest_q) && (oldest_q != '0) && (end_q >= SW'(oldest_q));

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    oldest_d     = oldest_q;
    newest_d     = newest_q;
    pull_pos_d   = pull_pos_q;
    pull_addr_d  = pull_addr_q;
    pull_valid_d = pull_valid_q;
    write_ptr_d  = write_ptr_q;
    push_rem_d   = push_rem_q;
    pull_off_d   = pull_off_q;
    clr_cnt_d    = clr_cnt_q;
    hpos_d       = hpos_q;
    hlo_d        = hlo_q;
    npos_d       = npos_q;
    end_d        = end_q;
    nsz_d        = nsz_q;
    len_d        = len_q;
    phase_d      = phase_q;
    sz_d         = sz_q;
    plen_d       = plen_q;
    rdflag_d     = rdflag_q;
    byte_d       = byte_q;
    done_d       = 1'b0;
    obyte_d      = 8'd0;
    olen_d       = 12'd0;
    olast_d      = 1'b0;
    ostat_d      = ST_OK;
    mem_we       = 1'b0;
    mem_waddr    = write_ptr_q;
    mem_wdata    = data_byte_i;
    mem_raddr    = hpos_q;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = 8'd0;
        clr_cnt_d = clr_cnt_q + PW'(1);
        if (clr_cnt_q == PW'(CAPACITY - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          case (opcode_i)
            OP_PUSH_START: begin
              if (SW'(nsz_in) > ring_len) begin
                push_rem_d = 12'd0;
                done_d     = 1'b1;
                ostat_d    = ST_TOO_LARGE;
              end else begin
                nsz_d   = nsz_in;
                len_d   = msg_length_i;
                phase_d = 1'b0;
                hpos_d  = newest_q;
                ret_d   = R_NEWEST;
                state_d = S_HLO;
              end
            end
            OP_PUSH_DATA: begin
              if (push_rem_q != 12'd0) begin
                mem_we      = 1'b1;
                write_ptr_d = inc_addr(write_ptr_q);
                push_rem_d  = push_rem_q - 12'd1;
              end
              done_d = 1'b1;
            end
            OP_PULL: begin
              if (!pull_valid_q) begin
                done_d  = 1'b1;
                ostat_d = ST_EMPTY;
              end else begin
                hpos_d  = pull_pos_q;
                ret_d   = R_PULL;
                state_d = S_HLO;
              end
            end
            default: begin
              pull_pos_d   = oldest_q;
              pull_addr_d  = add2(oldest_q);
              pull_off_d   = 12'd0;
              pull_valid_d = 1'b1;
              done_d       = 1'b1;
            end
          endcase
        end
      end
      S_HLO: begin
        mem_raddr = hpos_q;
        state_d   = S_HHI;
      end
      S_HHI: begin
        mem_raddr = inc_addr(hpos_q);
        hlo_d     = mem_rdata;
        state_d   = S_HEND;
      end
      S_HEND: begin
        case (ret_q)
          R_NEWEST: begin
            npos_d  = tail;
            end_d   = tail + SW'(nsz_q);
            state_d = S_DROP;
          end
          R_DROP: begin
            oldest_d = next_rec(oldest_q, hdr, ring_len);
            state_d  = S_DROP;
          end
          R_WRAP: begin
            oldest_d = next_rec(oldest_q, hdr, ring_len);
            newest_d = '0;
            npos_d   = '0;
            end_d    = SW'(nsz_q);
            phase_d  = 1'b1;
            state_d  = S_DROP;
          end
          R_PULL: begin
            sz_d = hdr;
            if (hdr < HDR_BYTES) begin
              pull_valid_d = 1'b0;
              pull_off_d   = 12'd0;
              pull_addr_d  = add2(pull_pos_q);
              done_d       = 1'b1;
              ostat_d      = ST_EMPTY;
              state_d      = S_IDLE;
            end else begin
              plen_d    = (plen_raw > 16'(MAX_LEN)) ? MAX_LEN : plen_raw[11:0];
              rdflag_d  = 1'b0;
              mem_raddr = pull_addr_q;
              if (plen_raw != 16'd0 && 16'(pull_off_q) < plen_raw) begin
                rdflag_d = 1'b1;
              end
              state_d = S_PBYTE;
            end
          end
          default: begin
            // Record done: advance unless at the newest record's end.
            if (SW'(pull_pos_q) != tail) begin
              pull_pos_d  = nxt_pull;
              pull_addr_d = add2(nxt_pull);
            end else begin
              pull_addr_d = add2(pull_pos_q);
            end
            pull_off_d = 12'd0;
            if (pull_pos_q == newest_q) begin
              pull_valid_d = 1'b0;
            end
            done_d  = 1'b1;
            obyte_d = byte_q;
            olen_d  = plen_q;
            olast_d = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_DROP: begin
        if (drop_more) begin
          hpos_d  = oldest_q;
          ret_d   = R_DROP;
          state_d = S_HLO;
        end else if (!phase_q && oldest_q <= newest_q && end_q > ring_len) begin
          state_d = S_WNLO;
        end else begin
          state_d = S_PHLO;
        end
      end
      S_WNLO: begin
        mem_we    = 1'b1;
        mem_waddr = newest_q;
        mem_wdata = pad_sz[7:0];
        state_d   = S_WNHI;
      end
      S_WNHI: begin
        mem_we    = 1'b1;
        mem_waddr = inc_addr(newest_q);
        mem_wdata = pad_sz[15:8];
        hpos_d    = oldest_q;
        ret_d     = R_WRAP;
        state_d   = S_HLO;
      end
      S_PHLO: begin
        mem_we    = 1'b1;
        mem_waddr = npos_q[PW-1:0];
        mem_wdata = nsz_q[7:0];
        state_d   = S_PHHI;
      end
      S_PHHI: begin
        mem_we      = 1'b1;
        mem_waddr   = inc_addr(npos_q[PW-1:0]);
        mem_wdata   = {3'd0, nsz_q[12:8]};
        newest_d    = npos_q[PW-1:0];
        write_ptr_d = add2(npos_q[PW-1:0]);
        push_rem_d  = len_q;
        if (!pull_valid_q) begin
          pull_pos_d   = npos_q[PW-1:0];
          pull_addr_d  = add2(npos_q[PW-1:0]);
          pull_off_d   = 12'd0;
          pull_valid_d = 1'b1;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_PBYTE: begin
        byte_d = rdflag_q ? mem_rdata : 8'd0;
        if (rdflag_q) begin
          pull_addr_d = inc_addr(pull_addr_q);
        end
        pull_off_d = off_new;
        if (off_new >= plen_q) begin
          // Record done: the newest header decides whether the cursor moves.
          hpos_d  = newest_q;
          ret_d   = R_PULLN;
          state_d = S_HLO;
        end else begin
          done_d  = 1'b1;
          obyte_d = rdflag_q ? mem_rdata : 8'd0;
          olen_d  = plen_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      ret_q        <= R_NEWEST;
      ring_size_q  <= RING_RESET;
      oldest_q     <= '0;
      newest_q     <= '0;
      pull_pos_q   <= '0;
      pull_addr_q  <= PW'(2);
      pull_valid_q <= 1'b1;
      write_ptr_q  <= '0;
      push_rem_q   <= 12'd0;
      pull_off_q   <= 12'd0;
      clr_cnt_q    <= '0;
      phase_q      <= 1'b0;
      rdflag_q     <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      if (cfg_we_i) begin
        ring_size_q <= cfg_wdata_i;
      end
      oldest_q     <= oldest_d;
      newest_q     <= newest_d;
      pull_pos_q   <= pull_pos_d;
      pull_addr_q  <= pull_addr_d;
      pull_valid_q <= pull_valid_d;
      write_ptr_q  <= write_ptr_d;
      push_rem_q   <= push_rem_d;
      pull_off_q   <= pull_off_d;
      clr_cnt_q    <= clr_cnt_d;
      phase_q      <= phase_d;
      rdflag_q     <= rdflag_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hpos_q  <= hpos_d;
    hlo_q   <= hlo_d;
    npos_q  <= npos_d;
    end_q   <= end_d;
    nsz_q   <= nsz_d;
    len_q   <= len_d;
    sz_q    <= sz_d;
    plen_q  <= plen_d;
    byte_q  <= byte_d;
    obyte_q <= obyte_d;
    olen_q  <= olen_d;
    olast_q <= olast_d;
    ostat_q <= ostat_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign out_byte_o   = obyte_q;
  assign out_length_o = olen_q;
  assign last_byte_o  = olast_q;
  assign status_o     = ostat_q;

`ifndef NO_ASSERTIONS
  // An accepted transaction either keeps the block busy or completes at once.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted transaction neither in progress nor completed");

  // A record end is only reported with an ok status.
  a_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && last_byte_o) |-> (status_o == ST_OK))
    else $error("record end reported with error status");

  // Pending payload never exceeds the largest message.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_rem_q <= MAX_LEN)
    else $error("push remaining count out of range");

  // No result is produced while the store is being cleared.
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !done_o)
    else $error("result during clearing pass");
`endif

endmodule

[sv/ormrb_ram.sv]
// Byte memory for the ring buffer store, with one write port and one read port.
// Synchronous write, registered read. No dependencies.
module ormrb_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
